// ===== src/mst_pkg.sv =====
`default_nettype none

package mst_pkg;

  // Fixed field widths of the request and response
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE = 1'b1;

  // Configuration reset values
  localparam logic [CNT_W-1:0]  LEAF_COUNT_RST = 11'd1024;
  localparam logic [DATA_W-1:0] FILL_VALUE_RST = 16'hFFFF;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  upper;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] min_value;
    logic              range_error;
  } rsp_t;

  // Port strobes of the node store
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/mst_store.sv =====
`default_nettype none

// Node store: one write port, one registered read port, and a sweep that
// sets every entry to all ones after reset.
module mst_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mst_pkg::mem_ctl_t  ctl_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  wire logic [DW-1:0]      wr_data_i,
  output logic      [DW-1:0]      rd_data_o,
  output logic                    busy_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr_q;
  logic          clearing_q;
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '1;
    end else if (ctl_i.wr) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clearing_q;

endmodule

`default_nettype wire

// ===== src/min_segment_tree.sv =====
`default_nettype none

// Minimum segment tree over up to LEAVES leaves, nodes numbered from 1 with
// children 2p and 2p+1 and each span split at its midpoint. An update request
// lowers one leaf to the smaller of its value and the new value and refreshes
// the path to the root; it gives no response, and a position at or beyond the
// leaf count is dropped. A query request gives one response: the minimum over
// position..upper clipped by fill_value, or fill_value with range_error set if
// the range is reversed or reaches past the leaf count. Items are handled one
// at a time through a single node store with one read and one write port,
// one tree level per cycle. An update walks down to the leaf, then does one
// read and one write per level on the way up; a query walks the two
// boundaries in turn, which share the read port, one node per cycle. After
// reset the store is swept to all ones, one entry a cycle, over all 4*LEAVES
// entries; requests stall during the sweep, configuration writes are taken at
// any time but belong only to idle periods.
module min_segment_tree #(
  parameter int unsigned LEAVES      = 1024,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mst_pkg::DATA_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire mst_pkg::req_t                   in_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output mst_pkg::rsp_t                        out_rsp_o
);

  localparam int unsigned DEPTH = 4 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = mst_pkg::CNT_W;
  localparam int unsigned CW    = (VALUE_WIDTH > mst_pkg::DATA_W) ? VALUE_WIDTH
                                                                  : mst_pkg::DATA_W;
  localparam int unsigned LW    = (mst_pkg::CNT_W > $clog2(LEAVES + 1))
                                  ? mst_pkg::CNT_W : $clog2(LEAVES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_DESC,
    S_UP_LEAF,
    S_UP_CLIMB,
    S_Q_SPLIT,
    S_Q_LEFT,
    S_Q_RIGHT,
    S_Q_DRAIN,
    S_Q_EMIT
  } state_e;

  // Configuration
  logic [mst_pkg::CNT_W-1:0]  leaf_count_q;
  logic [mst_pkg::DATA_W-1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= mst_pkg::LEAF_COUNT_RST;
      fill_q       <= mst_pkg::FILL_VALUE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mst_pkg::REG_LEAF_COUNT) begin
        leaf_count_q <= cfg_data_i[mst_pkg::CNT_W-1:0];
      end else begin
        fill_q <= cfg_data_i;
      end
    end
  end

  // Leaves in use: the leaf count, capped at the tree size
  logic [LW-1:0] lc_ext;
  logic [LW-1:0] n_ext;
  logic [SW-1:0] n_leaves;
  logic [SW-1:0] n_last;

  assign lc_ext   = LW'(leaf_count_q);
  assign n_ext    = (lc_ext > LW'(LEAVES)) ? LW'(LEAVES) : lc_ext;
  assign n_leaves = n_ext[SW-1:0];
  assign n_last   = n_leaves - SW'(1);

  // Sequencer and datapath registers
  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  mst_pkg::rsp_t      out_rsp_q, out_rsp_d;
  logic               rd_pend_q, rd_pend_d;

  logic [SW-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]          node_q, node_d;
  logic [SW-1:0]          rlo_q, rlo_d, rhi_q, rhi_d;
  logic [AW-1:0]          rnode_q, rnode_d;
  logic [SW-1:0]          a_q, a_d, b_q, b_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]          acc_q, acc_d;
  logic                   err_q, err_d;

  // Node store
  mst_pkg::mem_ctl_t      mem_ctl;
  logic [AW-1:0]          mem_rd_addr;
  logic [AW-1:0]          mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic [VALUE_WIDTH-1:0] mem_rd_data;
  logic                   mem_busy;

  mst_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (VALUE_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data),
    .busy_o    (mem_busy)
  );

  // Handshake
  logic in_accept;
  logic out_free;

  assign in_stall_o = mem_busy || (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Request decode
  logic [SW-1:0] pos_ext;
  logic [SW-1:0] up_ext;
  logic          upd_ok;
  logic          q_bad;

  assign pos_ext = SW'(in_req_i.position);
  assign up_ext  = SW'(in_req_i.upper);
  assign upd_ok  = pos_ext < n_leaves;
  assign q_bad   = (pos_ext > up_ext) || (up_ext >= n_leaves);

  // Walk helpers: midpoint of the current span and neighboring node indexes
  logic [SW:0]            mid_sum;
  logic [SW-1:0]          mid;
  logic [SW-1:0]          mid_p1;
  logic [AW-1:0]          node_l, node_r, node_up, node_sib, up_sib;
  logic [VALUE_WIDTH-1:0] path_min;
  logic [CW-1:0]          rd_ext;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[SW:1];
  assign mid_p1   = mid + SW'(1);
  assign node_l   = {node_q[AW-2:0], 1'b0};
  assign node_r   = {node_q[AW-2:0], 1'b1};
  assign node_up  = {1'b0, node_q[AW-1:1]};
  assign node_sib = {node_q[AW-1:1], ~node_q[0]};
  assign up_sib   = {node_up[AW-1:1], ~node_up[0]};
  // Leaf update and parent refresh both take the smaller of the running
  // path value and the word just read
  assign path_min = (mem_rd_data < val_q) ? mem_rd_data : val_q;
  assign rd_ext   = CW'(mem_rd_data);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    rd_pend_d   = 1'b0;
    lo_d        = lo_q;
    hi_d        = hi_q;
    node_d      = node_q;
    rlo_d       = rlo_q;
    rhi_d       = rhi_q;
    rnode_d     = rnode_q;
    a_d         = a_q;
    b_d         = b_q;
    val_d       = val_q;
    acc_d       = acc_q;
    err_d       = err_q;
    mem_ctl     = '0;
    mem_rd_addr = node_q;
    mem_wr_addr = node_q;
    mem_wr_data = path_min;

    // Drop the response once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // Fold in the node read issued last cycle
    if (rd_pend_q && (rd_ext < acc_q)) begin
      acc_d = rd_ext;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          lo_d   = '0;
          hi_d   = n_last;
          node_d = AW'(1);
          a_d    = pos_ext;
          b_d    = up_ext;
          if (in_req_i.cmd == mst_pkg::CMD_UPDATE) begin
            val_d = VALUE_WIDTH'(in_req_i.value);
            if (upd_ok) begin
              state_d = S_UP_DESC;
            end
          end else begin
            acc_d   = CW'(fill_q);
            err_d   = q_bad;
            state_d = q_bad ? S_Q_EMIT : S_Q_SPLIT;
          end
        end
      end

      // Update: walk down to the leaf, then climb back refreshing parents
      S_UP_DESC: begin
        if (lo_q == hi_q) begin
          mem_ctl.rd = 1'b1;
          state_d    = S_UP_LEAF;
        end else if (a_q <= mid) begin
          hi_d   = mid;
          node_d = node_l;
        end else begin
          lo_d   = mid_p1;
          node_d = node_r;
        end
      end

      S_UP_LEAF: begin
        mem_ctl.wr = 1'b1;
        val_d      = path_min;
        if (node_q == AW'(1)) begin
          state_d = S_IDLE;
        end else begin
          mem_ctl.rd  = 1'b1;
          mem_rd_addr = node_sib;
          state_d     = S_UP_CLIMB;
        end
      end

      S_UP_CLIMB: begin
        mem_ctl.wr  = 1'b1;
        mem_wr_addr = node_up;
        val_d       = path_min;
        node_d      = node_up;
        if (node_up == AW'(1)) begin
          state_d = S_IDLE;
        end else begin
          mem_ctl.rd  = 1'b1;
          mem_rd_addr = up_sib;
        end
      end

      // Query: descend to the split node, then walk the left and right
      // boundaries, reading each fully covered node on the way
      S_Q_SPLIT: begin
        if ((a_q <= lo_q) && (hi_q <= b_q)) begin
          mem_ctl.rd = 1'b1;
          rd_pend_d  = 1'b1;
          state_d    = S_Q_DRAIN;
        end else if (b_q <= mid) begin
          hi_d   = mid;
          node_d = node_l;
        end else if (a_q > mid) begin
          lo_d   = mid_p1;
          node_d = node_r;
        end else begin
          rlo_d   = mid_p1;
          rhi_d   = hi_q;
          rnode_d = node_r;
          hi_d    = mid;
          node_d  = node_l;
          state_d = S_Q_LEFT;
        end
      end

      S_Q_LEFT: begin
        if (a_q <= lo_q) begin
          mem_ctl.rd = 1'b1;
          rd_pend_d  = 1'b1;
          lo_d       = rlo_q;
          hi_d       = rhi_q;
          node_d     = rnode_q;
          state_d    = S_Q_RIGHT;
        end else if (a_q <= mid) begin
          mem_ctl.rd  = 1'b1;
          mem_rd_addr = node_r;
          rd_pend_d   = 1'b1;
          hi_d        = mid;
          node_d      = node_l;
        end else begin
          lo_d   = mid_p1;
          node_d = node_r;
        end
      end

      S_Q_RIGHT: begin
        if (hi_q <= b_q) begin
          mem_ctl.rd = 1'b1;
          rd_pend_d  = 1'b1;
          state_d    = S_Q_DRAIN;
        end else if (b_q > mid) begin
          mem_ctl.rd  = 1'b1;
          mem_rd_addr = node_l;
          rd_pend_d   = 1'b1;
          lo_d        = mid_p1;
          node_d      = node_r;
        end else begin
          hi_d   = mid;
          node_d = node_l;
        end
      end

      // Last read folds in this cycle
      S_Q_DRAIN: begin
        state_d = S_Q_EMIT;
      end

      // Hold until the response register is free
      S_Q_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_rsp_d.min_value   = acc_q[mst_pkg::DATA_W-1:0];
          out_rsp_d.range_error = err_q;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    node_q  <= node_d;
    rlo_q   <= rlo_d;
    rhi_q   <= rhi_d;
    rnode_q <= rnode_d;
    a_q     <= a_d;
    b_q     <= b_d;
    val_q   <= val_d;
    acc_q   <= acc_d;
    err_q   <= err_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTHESIS
  // No request may enter while the store is still being swept
  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> in_stall_o)
    else $error("request accepted during store sweep");

  // The update climb never reads the entry it writes in the same cycle
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.rd && mem_ctl.wr) |-> (mem_rd_addr != mem_wr_addr))
    else $error("node store read and write collide");

  // Pending read data is folded only after a query walk issued it
  a_pend_from_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == S_Q_SPLIT || $past(state_q) == S_Q_LEFT ||
                   $past(state_q) == S_Q_RIGHT))
    else $error("query read pending outside a walk");
`endif

endmodule

`default_nettype wire
